// ===== rtl/awf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awf_pkg
// types, codes and constants shared by the adaptive wiener filter modules
// ----------------------------------------------------------------------------
package awf_pkg;

    typedef struct packed {
        logic       op;
        logic [7:0] pixel;
    } awf_in_t;

    typedef struct packed {
        logic [7:0] filtered;
        logic       last;
    } awf_out_t;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [1:0] REG_NOISE  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam int RING_ROWS = 8;
    localparam int WIN_TAPS  = 25;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_OUT
    } awf_state_t;

    // statistics handed from the window reader to the divider
    typedef struct packed {
        logic [42:0] num;
        logic [41:0] den;
    } awf_div_req_t;

endpackage

// ===== rtl/awf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awf_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module awf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/awf_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awf_divider
// restoring divider, one quotient bit per cycle, round half even, saturate
// ----------------------------------------------------------------------------
module awf_divider (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  awf_pkg::awf_div_req_t req,
    output logic                  done,
    output logic [7:0]            quot
);
    import awf_pkg::*;

    // quotient never needs more than 9 bits before saturation test, but the
    // numerator may be far larger: 43 quotient bits are produced
    localparam int QB = 43;

    logic [42:0] num_reg, num_next;
    logic [42:0] q_reg, q_next;
    logic [42:0] rem_reg, rem_next;
    logic [41:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [7:0]  quot_reg, quot_next;
    logic [43:0] trial;
    logic [43:0] twice_r;
    logic        up;
    logic [43:0] qr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    always_comb
    begin
        num_next  = num_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        trial     = {rem_reg, num_reg[42]} - {2'b00, den_reg};
        twice_r   = {rem_reg, 1'b0};
        up        = 1'b0;
        qr        = '0;
        if (start)
        begin
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = 6'(QB);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 6'd0)
            begin
                if (!trial[43])
                begin
                    rem_next = trial[42:0];
                    q_next   = {q_reg[41:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[41:0], num_reg[42]};
                    q_next   = {q_reg[41:0], 1'b0};
                end
                num_next = {num_reg[41:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
            end
            else
            begin
                up = (twice_r > {2'b00, den_reg}) ||
                     ((twice_r == {2'b00, den_reg}) && q_reg[0]);
                qr = {1'b0, q_reg} + {43'd0, up};
                quot_next = (qr > 44'd255) ? 8'hFF : qr[7:0];
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule

// ===== rtl/adaptive_wiener_pixel_filter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_wiener_pixel_filter_core
// 5x5 adaptive wiener filter over a raster stream of 8-bit gray pixels
// ----------------------------------------------------------------------------
// usage: send beats on in_valid/in (op 0 = pixel, op 1 = flush tick); a beat
// is taken when in_valid is high and in_stall low. results leave on
// out_valid/out, taken when out_stall is low. a pixel goes into an 8-row
// line ring in one ram. once a result is due, the 25 window pixels are read
// from that ram one per cycle (border rows and columns replicated), sum and
// sum of squares accumulated, then a bit-serial divider forms the rounded
// quotient. an item that causes no result leaves the core idle; one that
// causes a result holds in_stall high while the window reads, the
// statistics and the divider run in turn, paced by the single ram read port
// and the one-bit-per-cycle divider, and the result beat is then written to
// the output register. results appear 2*width+2 pixels after their own
// pixel; flush ticks drain the rest of an image.
// reset clears counts and the output valid and loads noise 5000 and
// 1024x1024 geometry; the ram needs no clearing. a stalled result holds in
// the output register; beats that cause no result are still taken, and the
// next result waits in the divider until the register frees up.
// ----------------------------------------------------------------------------
module adaptive_wiener_pixel_filter_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  awf_pkg::awf_in_t in,
    output logic             out_valid,
    input  logic             out_stall,
    output awf_pkg::awf_out_t out,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data
);
    import awf_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int CW1 = $clog2(MAX_WIDTH + 1);
    localparam int RW1 = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = RING_ROWS * (1 << CW);
    localparam int AW  = $clog2(DEPTH);

    logic [15:0] noise_reg;
    logic [10:0] width_cfg_reg, height_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_reg      <= 16'd5000;
            width_cfg_reg  <= 11'd1024;
            height_cfg_reg <= 11'd1024;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NOISE:  noise_reg      <= cfg_data;
                REG_WIDTH:  width_cfg_reg  <= cfg_data[10:0];
                REG_HEIGHT: height_cfg_reg <= cfg_data[10:0];
                default:    ;
            endcase
        end
    end

    // effective geometry
    logic [CW1-1:0] w;
    logic [RW1-1:0] h;
    always_comb
    begin
        if (width_cfg_reg == 11'd0)
            w = CW1'(1);
        else if (32'(width_cfg_reg) > MAX_WIDTH)
            w = CW1'(MAX_WIDTH);
        else
            w = CW1'(width_cfg_reg);
        if (height_cfg_reg == 11'd0)
            h = RW1'(1);
        else if (32'(height_cfg_reg) > MAX_HEIGHT)
            h = RW1'(MAX_HEIGHT);
        else
            h = RW1'(height_cfg_reg);
    end

    // counters kept as row/column pairs
    logic [RW1-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [CW1-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [CW1+1:0] pend_reg, pend_next;   // in_count - out_count
    logic           in_done_reg, in_done_next;

    awf_state_t state_reg, state_next;
    logic [4:0] tap_reg, tap_next;
    logic [4:0] acc_tap_reg, acc_tap_next;
    logic       acc_v_reg, acc_v_next;
    logic [12:0] s_reg, s_next;
    logic [20:0] q_reg, q_next;
    logic [7:0]  x_reg, x_next;
    logic [1:0]  fin_reg, fin_next;
    logic        ov_reg, ov_next;
    awf_out_t    out_reg, out_next;

    // ram ports
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    rdata;

    awf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_line (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(in.pixel),
        .raddr(raddr),
        .rdata(rdata)
    );

    // window address for current tap
    logic signed [RW1+1:0] rr;
    logic signed [CW1+1:0] cc;
    logic [2:0] dyi, dxi;
    always_comb
    begin
        // tap to row and column offset by compare and subtract
        if (tap_reg >= 5'd20)
        begin
            dyi = 3'd4;
            dxi = 3'(tap_reg - 5'd20);
        end
        else if (tap_reg >= 5'd15)
        begin
            dyi = 3'd3;
            dxi = 3'(tap_reg - 5'd15);
        end
        else if (tap_reg >= 5'd10)
        begin
            dyi = 3'd2;
            dxi = 3'(tap_reg - 5'd10);
        end
        else if (tap_reg >= 5'd5)
        begin
            dyi = 3'd1;
            dxi = 3'(tap_reg - 5'd5);
        end
        else
        begin
            dyi = 3'd0;
            dxi = 3'(tap_reg);
        end
        rr = $signed({2'b00, out_row_reg}) + $signed((RW1+2)'(dyi)) - (RW1+2)'(2);
        cc = $signed({2'b00, out_col_reg}) + $signed((CW1+2)'(dxi)) - (CW1+2)'(2);
        if (rr < 0)
            rr = '0;
        else if (rr > $signed({2'b00, h}) - (RW1+2)'(1))
            rr = $signed({2'b00, h}) - (RW1+2)'(1);
        if (cc < 0)
            cc = '0;
        else if (cc > $signed({2'b00, w}) - (CW1+2)'(1))
            cc = $signed({2'b00, w}) - (CW1+2)'(1);
        raddr = {rr[2:0], cc[CW-1:0]};
    end

    // statistics to divider request
    localparam logic [41:0] K625 = 42'd625;
    logic [41:0] v_w, d_w, num_w, den_w, ss_w;
    logic [25:0] s_sq_w;
    logic signed [39:0] prod_b_w;
    logic signed [14:0] diff_w;
    awf_div_req_t req_next;
    logic [41:0]  v_reg, v_next, ssq_reg, ssq_next;
    logic         div_start;
    logic         div_done;
    logic [7:0]   div_q;

    always_comb
    begin
        s_sq_w   = s_reg * s_reg;
        ss_w     = 42'(s_sq_w);
        v_w      = v_reg;
        d_w      = K625 * 42'(noise_reg);
        num_w    = (v_w > d_w) ? (v_w - d_w) : '0;
        den_w    = (v_w > d_w) ? v_w : d_w;
        diff_w   = $signed(15'(25) * $signed({7'd0, x_reg})) - $signed({2'b00, s_reg});
        // 625 * variance stays below 2^24
        prod_b_w = $signed({1'b0, num_w[23:0]}) * diff_w;
    end

    logic accept_in;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept_in = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign out       = out_reg;

    // multiplies between registers: s squared, then v, then the denominator and product b, then product a
    logic signed [43:0] prod_a_reg, prod_a_next, prod_b_reg, prod_b_next;
    logic [41:0] den_reg, den_next;
    logic [38:0] prod_a_w;

    // the denominator register stays below 2^26
    assign prod_a_w = s_reg * den_reg[25:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            pend_reg      <= '0;
            in_done_reg   <= 1'b0;
            ov_reg        <= 1'b0;
            acc_v_reg     <= 1'b0;
            tap_reg       <= '0;
            fin_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            pend_reg      <= pend_next;
            in_done_reg   <= in_done_next;
            ov_reg        <= ov_next;
            acc_v_reg     <= acc_v_next;
            tap_reg       <= tap_next;
            fin_reg       <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_tap_reg   <= acc_tap_next;
        s_reg         <= s_next;
        q_reg         <= q_next;
        x_reg         <= x_next;
        out_reg       <= out_next;
        v_reg         <= v_next;
        ssq_reg       <= ssq_next;
        prod_a_reg    <= prod_a_next;
        prod_b_reg    <= prod_b_next;
        den_reg       <= den_next;
    end

    logic         zero_den;
    logic         zero_den_reg, zero_den_next;
    always_ff @(posedge clk)
    begin
        zero_den_reg <= zero_den_next;
    end

    // a pixel beat when the image is not complete
    logic img_full;   // all pixels in
    logic lag_hit;
    logic out_is_last;
    assign img_full    = in_done_reg;
    assign lag_hit     = (pend_reg + (CW1+2)'(1)) > ({1'b0, w, 1'b0} + (CW1+2)'(2));
    assign out_is_last = (out_row_reg == h - RW1'(1)) && (out_col_reg == w - CW1'(1));
    assign zero_den    = (den_reg == '0);

    always_comb
    begin
        state_next     = state_reg;
        in_row_next    = in_row_reg;
        in_col_next    = in_col_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        pend_next      = pend_reg;
        in_done_next   = in_done_reg;
        ov_next        = ov_reg && out_stall;
        acc_v_next     = 1'b0;
        acc_tap_next   = tap_reg;
        tap_next       = tap_reg;
        s_next         = s_reg;
        q_next         = q_reg;
        x_next         = x_reg;
        fin_next       = fin_reg;
        out_next       = out_reg;
        v_next         = v_reg;
        ssq_next       = ssq_reg;
        prod_a_next    = prod_a_reg;
        prod_b_next    = prod_b_reg;
        den_next       = den_reg;
        zero_den_next  = zero_den_reg;
        we             = 1'b0;
        waddr          = {in_row_reg[2:0], in_col_reg[CW-1:0]};
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    if (!img_full)
                    begin
                        if (in.op == OP_PIXEL)
                        begin
                            we = 1'b1;
                            pend_next = pend_reg + (CW1+2)'(1);
                            if (in_col_reg == w - CW1'(1))
                            begin
                                in_col_next = '0;
                                in_row_next = in_row_reg + RW1'(1);
                                if (in_row_reg == h - RW1'(1))
                                    in_done_next = 1'b1;
                            end
                            else
                            begin
                                in_col_next = in_col_reg + CW1'(1);
                            end
                            if (lag_hit)
                            begin
                                state_next = ST_READ;
                                tap_next   = '0;
                            end
                        end
                    end
                    else
                    begin
                        state_next = ST_READ;
                        tap_next   = '0;
                    end
                    s_next = '0;
                    q_next = '0;
                end
            end
            ST_READ:
            begin
                // tap issued this cycle, data next cycle
                if (tap_reg != 5'(WIN_TAPS))
                begin
                    acc_v_next = 1'b1;
                    tap_next   = tap_reg + 5'd1;
                end
                if (acc_v_reg)
                begin
                    s_next = s_reg + 13'(rdata);
                    q_next = q_reg + 21'(16'(rdata) * 16'(rdata));
                    if (acc_tap_reg == 5'd12)
                        x_next = rdata;
                end
                if (!acc_v_reg && tap_reg == 5'(WIN_TAPS))
                begin
                    state_next = ST_DIV;
                    fin_next   = '0;
                end
            end
            ST_DIV:
            begin
                fin_next = fin_reg + 2'd1;
                case (fin_reg)
                    2'd0:
                    begin
                        ssq_next = ss_w;
                    end
                    2'd1:
                    begin
                        v_next = 42'd25 * 42'(q_reg) - ssq_reg;
                    end
                    2'd2:
                    begin
                        den_next    = den_w;
                        prod_b_next = 44'(prod_b_w);
                    end
                    default:
                    begin
                        prod_a_next   = $signed(44'(prod_a_w));
                        zero_den_next = zero_den;
                        state_next    = ST_OUT;
                        fin_next      = '0;
                    end
                endcase
            end
            ST_OUT:
            begin
                if (fin_reg == 2'd0)
                begin
                    fin_next = 2'd1;
                end
                else if (div_done || (fin_reg == 2'd2))
                begin
                    if (ov_reg && out_stall)
                    begin
                        // output register still taken, quotient held in the divider
                        fin_next = 2'd2;
                    end
                    else
                    begin
                        out_next.filtered = div_q;
                        out_next.last     = out_is_last;
                        ov_next           = 1'b1;
                        pend_next         = pend_reg - (CW1+2)'(1);
                        if (out_is_last)
                        begin
                            in_row_next  = '0;
                            in_col_next  = '0;
                            out_row_next = '0;
                            out_col_next = '0;
                            pend_next    = '0;
                            in_done_next = 1'b0;
                        end
                        else if (out_col_reg == w - CW1'(1))
                        begin
                            out_col_next = '0;
                            out_row_next = out_row_reg + RW1'(1);
                        end
                        else
                        begin
                            out_col_next = out_col_reg + CW1'(1);
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // forms the divider request from the product registers, or from the window sum when the denominator is zero
    logic signed [44:0] nsum;
    always_comb
    begin
        nsum = $signed({prod_a_reg[43], prod_a_reg}) + $signed({prod_b_reg[43], prod_b_reg});
    end

    always_comb
    begin
        if (zero_den_reg)
        begin
            req_next.num = 43'(s_reg);
            req_next.den = 42'd25;
        end
        else
        begin
            req_next.num = nsum[44] ? '0 : nsum[42:0];
            req_next.den = 42'd25 * den_reg;
        end
    end

    assign div_start = (state_reg == ST_OUT) && (fin_reg == 2'd0);

    awf_divider u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .req  (req_next),
        .done (div_done),
        .quot (div_q)
    );

    ap_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !accept_in)
        else $error("item accepted while busy");
    ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> (ov_reg && $stable(out_reg)))
        else $error("stalled result changed");
    ap_done_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_OUT))
        else $error("divider done outside output state");
endmodule
